// File: src/kttwa_pkg.sv
// Package for the keyed track table with aging.
// Item structs, op codes, result status codes, limits, controller state type and cmd/stat structs.
// No dependencies.
`default_nettype none
package kttwa_pkg;

  typedef struct packed {
    logic        op;
    logic        source_valid;
    logic [23:0] aircraft_key;
    logic [31:0] now_ms;
  } in_item_t;

  typedef struct packed {
    logic [2:0] status;
    logic [3:0] slot;
    logic [4:0] active_count;
    logic [4:0] stale_count;
  } out_item_t;

  localparam logic       OP_REPORT = 1'b0;
  localparam logic       OP_PRUNE  = 1'b1;

  localparam logic [2:0] ST_IGNORED = 3'd0;
  localparam logic [2:0] ST_MATCHED = 3'd1;
  localparam logic [2:0] ST_NEW     = 3'd2;
  localparam logic [2:0] ST_FULL    = 3'd3;
  localparam logic [2:0] ST_PRUNED  = 3'd4;

  localparam logic [31:0] TIMEOUT_RESET = 32'd60000;
  localparam logic [7:0]  COUNT_MAX     = 8'd31;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FLUSH,
    S_COMMIT
  } state_t;

  typedef struct packed {
    logic load;
    logic issue;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic skip;
    logic last_addr;
    logic out_free;
  } stat_t;

endpackage
`default_nettype wire

// File: src/kttwa_ctrl.sv
// Controller state machine for the track table.
// Sequences load, table scan and commit; uses kttwa_pkg.
`default_nettype none
module kttwa_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  input  wire kttwa_pkg::stat_t st,
  output kttwa_pkg::cmd_t      cmd,
  output logic                 in_stall
);

  kttwa_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= kttwa_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    case (state)
      kttwa_pkg::S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = st.skip ? kttwa_pkg::S_COMMIT : kttwa_pkg::S_SCAN;
        end
      end
      kttwa_pkg::S_SCAN: begin
        cmd.issue = 1'b1;
        if (st.last_addr) begin
          state_next = kttwa_pkg::S_FLUSH;
        end
      end
      kttwa_pkg::S_FLUSH: begin
        state_next = kttwa_pkg::S_COMMIT;
      end
      kttwa_pkg::S_COMMIT: begin
        if (st.out_free) begin
          cmd.commit = 1'b1;
          state_next = kttwa_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = kttwa_pkg::S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

// File: src/kttwa_dp.sv
// Datapath for the track table: key and time memories, valid/stale bits,
// scan pipeline, counters and output register. Uses kttwa_pkg.
`default_nettype none
module kttwa_dp #(
  parameter int TRACKS = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_we,
  input  wire logic [31:0]          cfg_wdata,
  input  wire kttwa_pkg::in_item_t  in_item,
  input  wire kttwa_pkg::cmd_t      cmd,
  output kttwa_pkg::stat_t          st,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output kttwa_pkg::out_item_t      out_item
);

  localparam int IW   = (TRACKS > 1) ? $clog2(TRACKS) : 1;
  localparam int CNTW = $clog2(TRACKS + 1);

  logic [31:0]       timeout;
  logic              op_r;
  logic              srcv_r;
  logic [23:0]       key_r;
  logic [31:0]       now_r;

  logic [23:0]       key_mem [TRACKS];
  logic [31:0]       time_mem [TRACKS];
  logic [TRACKS-1:0] vld;
  logic [TRACKS-1:0] stl;

  logic [IW-1:0]     rd_addr;
  logic              pv;
  logic [IW-1:0]     pidx;
  logic [23:0]       pkey;
  logic [31:0]       ptime;

  logic              hit;
  logic [IW-1:0]     hit_idx;
  logic              free;
  logic [IW-1:0]     free_idx;
  logic [CNTW-1:0]   act_cnt;
  logic [CNTW-1:0]   stl_cnt;

  logic              e_v;
  logic              e_s;
  logic [31:0]       age;
  logic              n_v;
  logic              n_s;
  logic              mem_we;
  logic [IW-1:0]     widx;
  logic [7:0]        slot_ext;
  logic [7:0]        act_ext;
  logic [7:0]        stl_ext;
  kttwa_pkg::out_item_t result;

  assign st.skip      = (in_item.op == kttwa_pkg::OP_REPORT) && !in_item.source_valid;
  assign st.last_addr = (rd_addr == IW'(TRACKS - 1));
  assign st.out_free  = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout <= kttwa_pkg::TIMEOUT_RESET;
    end else if (cfg_we) begin
      timeout <= cfg_wdata;
    end
  end

  // scan entry evaluation
  assign e_v = vld[pidx];
  assign e_s = stl[pidx];
  assign age = now_r - ptime;
  assign n_v = e_v && !(age > timeout);
  assign n_s = n_v && (e_s || (age > (timeout >> 1)));

  assign mem_we = cmd.commit && (op_r == kttwa_pkg::OP_REPORT) && srcv_r && (hit || free);
  assign widx   = hit ? hit_idx : free_idx;

  always_ff @(posedge clk) begin
    if (cmd.issue) begin
      pkey  <= key_mem[rd_addr];
      ptime <= time_mem[rd_addr];
    end
    if (mem_we) begin
      key_mem[widx]  <= key_r;
      time_mem[widx] <= now_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r    <= in_item.op;
      srcv_r  <= in_item.source_valid;
      key_r   <= in_item.aircraft_key;
      now_r   <= in_item.now_ms;
      rd_addr <= '0;
      hit     <= 1'b0;
      free    <= 1'b0;
      act_cnt <= '0;
      stl_cnt <= '0;
    end else begin
      if (cmd.issue) begin
        rd_addr <= rd_addr + 1'b1;
      end
      if (pv) begin
        if (op_r == kttwa_pkg::OP_PRUNE) begin
          if (n_s) begin
            stl_cnt <= stl_cnt + 1'b1;
          end else if (n_v) begin
            act_cnt <= act_cnt + 1'b1;
          end
        end else begin
          if (e_v && (pkey == key_r) && !hit) begin
            hit     <= 1'b1;
            hit_idx <= pidx;
          end
          if (!e_v && !free) begin
            free     <= 1'b1;
            free_idx <= pidx;
          end
        end
      end
    end
    pidx <= rd_addr;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld       <= '0;
      stl       <= '0;
      pv        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      pv <= cmd.issue;
      if (pv && (op_r == kttwa_pkg::OP_PRUNE)) begin
        vld[pidx] <= n_v;
        stl[pidx] <= n_s;
      end
      if (mem_we) begin
        vld[widx] <= 1'b1;
        stl[widx] <= 1'b0;
      end
      if (cmd.commit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign slot_ext = 8'(widx);
  assign act_ext  = 8'(act_cnt);
  assign stl_ext  = 8'(stl_cnt);

  always_comb begin
    result = '0;
    if (op_r == kttwa_pkg::OP_PRUNE) begin
      result.status       = kttwa_pkg::ST_PRUNED;
      result.active_count = (act_ext > kttwa_pkg::COUNT_MAX) ? 5'd31 : act_ext[4:0];
      result.stale_count  = (stl_ext > kttwa_pkg::COUNT_MAX) ? 5'd31 : stl_ext[4:0];
    end else if (!srcv_r) begin
      result.status = kttwa_pkg::ST_IGNORED;
    end else if (hit) begin
      result.status = kttwa_pkg::ST_MATCHED;
      result.slot   = slot_ext[3:0];
    end else if (free) begin
      result.status = kttwa_pkg::ST_NEW;
      result.slot   = slot_ext[3:0];
    end else begin
      result.status = kttwa_pkg::ST_FULL;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_item <= result;
    end
  end

endmodule
`default_nettype wire

// File: src/keyed_track_table_with_aging_unit.sv
// Top level of the keyed track table with aging.
// Joins kttwa_ctrl and kttwa_dp; uses kttwa_pkg.
//
//   channel   direction  handshake            payload
//   in        input      in_valid / in_stall  in_item  (kttwa_pkg::in_item_t)
//   out       output     out_valid/ out_stall out_item (kttwa_pkg::out_item_t)
//   cfg       input      cfg_we               cfg_wdata (stale_timeout_ms)
//
// A report or prune loads its result after a scan of the whole table:
// one read of the key/time memory per entry, one flush, one commit.
// An ignored report skips the scan and goes straight to commit.
// Synchronous reset clears valid and stale bits; timeout returns to 60000.
// A result held by out_stall holds the controller in commit; no item is
// taken until the scan and commit of the current one are done.
`default_nettype none
module keyed_track_table_with_aging_unit #(
  parameter int TRACKS = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_we,
  input  wire logic [31:0]          cfg_wdata,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire kttwa_pkg::in_item_t  in_item,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output kttwa_pkg::out_item_t      out_item
);

  kttwa_pkg::cmd_t  cmd;
  kttwa_pkg::stat_t st;

  kttwa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .st       (st),
    .cmd      (cmd),
    .in_stall (in_stall)
  );

  kttwa_dp #(
    .TRACKS (TRACKS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_item   (in_item),
    .cmd       (cmd),
    .st        (st),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule
`default_nettype wire

// File: src/kttwa_chk.sv
// Port-level checker for the track table, bound to the top level.
// Uses kttwa_pkg result codes.
`default_nettype none
module kttwa_chk (
  input wire logic                clk,
  input wire logic                rst,
  input wire logic                in_valid,
  input wire logic                in_stall,
  input wire kttwa_pkg::out_item_t out_item,
  input wire logic                out_valid,
  input wire logic                out_stall
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("stalled result changed");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("item accepted while busy");

  a_slot_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_item.status != kttwa_pkg::ST_MATCHED)
      && (out_item.status != kttwa_pkg::ST_NEW) |-> out_item.slot == 4'd0)
    else $error("slot set without match or allocation");

  a_counts_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_item.status != kttwa_pkg::ST_PRUNED)
      |-> (out_item.active_count == 5'd0) && (out_item.stale_count == 5'd0))
    else $error("counts set on a report result");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_item.status <= kttwa_pkg::ST_PRUNED)
    else $error("status code out of range");

endmodule

bind keyed_track_table_with_aging_unit kttwa_chk u_chk (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_item  (out_item),
  .out_valid (out_valid),
  .out_stall (out_stall)
);
`default_nettype wire
